// ===== sv/rls_pkg.sv =====
`default_nettype none

package rls_pkg;

   localparam int DEF_MAX_LINE_LEN = 4096;
   localparam int DEF_COUNT_BITS   = 24;

   localparam int LEN_OUT_W   = 13;
   localparam int TOTAL_OUT_W = 24;

   typedef struct packed {
      logic pixel;
      logic line_end;
      logic image_end;
   } rls_req_type;

   typedef struct packed {
      logic [LEN_OUT_W-1:0]   peak_length;
      logic [LEN_OUT_W-1:0]   median_length;
      logic [TOTAL_OUT_W-1:0] run_total;
   } rls_rsp_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_RUN,
      ST_DRAIN,
      ST_SUM,
      ST_RANK,
      ST_FINISH,
      ST_REPORT
   } rls_state_type;

endpackage

`default_nettype wire

// ===== sv/run_length_statistics_unit.sv =====
`default_nettype none

// Channel    Direction  Handshake          Payload
// req        in         req_valid/stall    rls_req_type  pixel, line_end, image_end
// rsp        out        rsp_valid/stall    rls_rsp_type  peak, median, run total
// csr        in         csr_write_enable   run polarity, one bit
//
// One pixel request per cycle while an image streams in.
// After an image-end request the histogram memory is walked twice (totals and peak,
// then ranks with clearing): input stalls through both walks, and longer
// while the previous result still waits in the output register.
// After reset the memory is cleared one bin a cycle, with req_stall held throughout.
// A finished result waits in an output register; the next image streams meanwhile.

module run_length_statistics_unit #(
   parameter int MAX_LINE_LEN = rls_pkg::DEF_MAX_LINE_LEN,
   parameter int COUNT_BITS   = rls_pkg::DEF_COUNT_BITS
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire rls_pkg::rls_req_type req_data,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output rls_pkg::rls_rsp_type      rsp_data,
   input  wire logic                 csr_write_enable,
   input  wire logic                 csr_write_data
);

   import rls_pkg::*;

   localparam int IDX_W = $clog2(MAX_LINE_LEN);

   logic                   polarity_ff, polarity_in;
   logic                   accept;
   logic                   img_done;
   logic                   inc_valid;
   logic [IDX_W-1:0]       inc_addr;
   logic [TOTAL_OUT_W-1:0] run_total;
   logic [COUNT_BITS-1:0]  rd_data;
   logic [IDX_W-1:0]       scan_addr;
   logic                   clr_valid;
   logic [IDX_W-1:0]       clr_addr;

   assign accept      = req_valid && !req_stall;
   assign img_done    = accept && req_data.image_end;
   assign polarity_in = csr_write_enable ? csr_write_data : polarity_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         polarity_ff <= 1'b1;
      end else begin
         polarity_ff <= polarity_in;
      end
   end

   rls_run_tracker #(
      .MAX_LINE_LEN (MAX_LINE_LEN),
      .COUNT_BITS   (COUNT_BITS)
   ) u_tracker (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .req       (req_data),
      .polarity  (polarity_ff),
      .inc_valid (inc_valid),
      .inc_addr  (inc_addr),
      .run_total (run_total)
   );

   rls_hist_port #(
      .MAX_LINE_LEN (MAX_LINE_LEN),
      .COUNT_BITS   (COUNT_BITS)
   ) u_hist (
      .clock     (clock),
      .reset     (reset),
      .inc_valid (inc_valid),
      .inc_addr  (inc_addr),
      .scan_addr (scan_addr),
      .clr_valid (clr_valid),
      .clr_addr  (clr_addr),
      .rd_data   (rd_data)
   );

   rls_walker #(
      .MAX_LINE_LEN (MAX_LINE_LEN),
      .COUNT_BITS   (COUNT_BITS)
   ) u_walker (
      .clock     (clock),
      .reset     (reset),
      .img_done  (img_done),
      .run_total (run_total),
      .rd_data   (rd_data),
      .req_stall (req_stall),
      .scan_addr (scan_addr),
      .clr_valid (clr_valid),
      .clr_addr  (clr_addr),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .rsp_stall (rsp_stall)
   );

endmodule

`default_nettype wire

// ===== sv/rls_ram.sv =====
`default_nettype none

module rls_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 4096
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

// ===== sv/rls_run_tracker.sv =====
`default_nettype none

module rls_run_tracker #(
   parameter int MAX_LINE_LEN = rls_pkg::DEF_MAX_LINE_LEN,
   parameter int COUNT_BITS   = rls_pkg::DEF_COUNT_BITS
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              accept,
   input  wire rls_pkg::rls_req_type              req,
   input  wire logic                              polarity,
   output logic                                   inc_valid,
   output logic [$clog2(MAX_LINE_LEN)-1:0]        inc_addr,
   output logic [rls_pkg::TOTAL_OUT_W-1:0]        run_total
);

   import rls_pkg::*;

   localparam int IDX_W = $clog2(MAX_LINE_LEN);
   localparam int LEN_W = $clog2(MAX_LINE_LEN + 1);
   localparam int RUN_W = (COUNT_BITS > TOTAL_OUT_W) ? COUNT_BITS : TOTAL_OUT_W;

   logic [LEN_W-1:0]      cur_len_ff, cur_len_in;
   logic [COUNT_BITS-1:0] runs_ff, runs_in;
   logic [COUNT_BITS-1:0] runs_next;
   logic [LEN_W-1:0]      len_inc;
   logic [LEN_W-1:0]      rec_len;
   logic [RUN_W-1:0]      runs_wide;
   logic                  match;
   logic                  ends;

   always_comb begin
      match   = (req.pixel == polarity);
      ends    = req.line_end | req.image_end;
      len_inc = (cur_len_ff < LEN_W'(MAX_LINE_LEN)) ? cur_len_ff + LEN_W'(1) : cur_len_ff;

      // a matching pixel closes its run only at line or image end
      if (match) begin
         rec_len = ends ? len_inc : '0;
      end else begin
         rec_len = cur_len_ff;
      end

      inc_valid = accept && (rec_len != '0);
      inc_addr  = IDX_W'(rec_len - LEN_W'(1));

      if (accept) begin
         cur_len_in = (match && !ends) ? len_inc : '0;
      end else begin
         cur_len_in = cur_len_ff;
      end

      runs_next = (inc_valid && (runs_ff != '1)) ? runs_ff + COUNT_BITS'(1) : runs_ff;
      runs_in   = (accept && req.image_end) ? '0 : runs_next;

      runs_wide = RUN_W'(runs_next);
      run_total = (runs_wide > RUN_W'({TOTAL_OUT_W{1'b1}})) ? '1 : TOTAL_OUT_W'(runs_wide);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_len_ff <= '0;
         runs_ff    <= '0;
      end else begin
         cur_len_ff <= cur_len_in;
         runs_ff    <= runs_in;
      end
   end

endmodule

`default_nettype wire

// ===== sv/rls_hist_port.sv =====
`default_nettype none

module rls_hist_port #(
   parameter int MAX_LINE_LEN = rls_pkg::DEF_MAX_LINE_LEN,
   parameter int COUNT_BITS   = rls_pkg::DEF_COUNT_BITS
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            inc_valid,
   input  wire logic [$clog2(MAX_LINE_LEN)-1:0] inc_addr,
   input  wire logic [$clog2(MAX_LINE_LEN)-1:0] scan_addr,
   input  wire logic                            clr_valid,
   input  wire logic [$clog2(MAX_LINE_LEN)-1:0] clr_addr,
   output logic      [COUNT_BITS-1:0]           rd_data
);

   import rls_pkg::*;

   localparam int IDX_W = $clog2(MAX_LINE_LEN);

   logic                  b_valid_ff, b_valid_in;
   logic [IDX_W-1:0]      b_addr_ff, b_addr_in;
   logic                  wb_valid_ff, wb_valid_in;
   logic [IDX_W-1:0]      wb_addr_ff, wb_addr_in;
   logic [COUNT_BITS-1:0] wb_data_ff, wb_data_in;

   logic [COUNT_BITS-1:0] cur_count;
   logic [COUNT_BITS-1:0] new_count;
   logic                  ram_we;
   logic [IDX_W-1:0]      ram_wa;
   logic [COUNT_BITS-1:0] ram_wd;
   logic [IDX_W-1:0]      ram_ra;

   rls_ram #(
      .WIDTH (COUNT_BITS),
      .DEPTH (MAX_LINE_LEN)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_wa),
      .wr_data (ram_wd),
      .rd_addr (ram_ra),
      .rd_data (rd_data)
   );

   always_comb begin
      ram_ra = inc_valid ? inc_addr : scan_addr;

      // the bin written on the edge that issued this read is stale in the RAM
      cur_count = (wb_valid_ff && (wb_addr_ff == b_addr_ff)) ? wb_data_ff : rd_data;
      new_count = (cur_count == '1) ? cur_count : cur_count + COUNT_BITS'(1);

      if (b_valid_ff) begin
         ram_we = 1'b1;
         ram_wa = b_addr_ff;
         ram_wd = new_count;
      end else begin
         ram_we = clr_valid;
         ram_wa = clr_addr;
         ram_wd = '0;
      end

      b_valid_in  = inc_valid;
      b_addr_in   = inc_addr;
      wb_valid_in = b_valid_ff;
      wb_addr_in  = b_addr_ff;
      wb_data_in  = new_count;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff  <= 1'b0;
         wb_valid_ff <= 1'b0;
      end else begin
         b_valid_ff  <= b_valid_in;
         wb_valid_ff <= wb_valid_in;
      end
      b_addr_ff  <= b_addr_in;
      wb_addr_ff <= wb_addr_in;
      wb_data_ff <= wb_data_in;
   end

endmodule

`default_nettype wire

// ===== sv/rls_walker.sv =====
`default_nettype none

module rls_walker #(
   parameter int MAX_LINE_LEN = rls_pkg::DEF_MAX_LINE_LEN,
   parameter int COUNT_BITS   = rls_pkg::DEF_COUNT_BITS
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            img_done,
   input  wire logic [rls_pkg::TOTAL_OUT_W-1:0] run_total,
   input  wire logic [COUNT_BITS-1:0]           rd_data,
   output logic                                 req_stall,
   output logic [$clog2(MAX_LINE_LEN)-1:0]      scan_addr,
   output logic                                 clr_valid,
   output logic [$clog2(MAX_LINE_LEN)-1:0]      clr_addr,
   output logic                                 rsp_valid,
   output rls_pkg::rls_rsp_type                 rsp_data,
   input  wire logic                            rsp_stall
);

   import rls_pkg::*;

   localparam int IDX_W = $clog2(MAX_LINE_LEN);
   localparam int LEN_W = $clog2(MAX_LINE_LEN + 1);
   localparam int TOT_W = COUNT_BITS + IDX_W + 1;

   rls_state_type state_ff, state_in;

   logic [IDX_W-1:0]       scan_ff, scan_in;
   logic                   rd_valid_ff, rd_valid_in;
   logic                   rd_rank_ff, rd_rank_in;
   logic [IDX_W-1:0]       rd_idx_ff, rd_idx_in;

   logic [TOT_W-1:0]       total_ff, total_in;
   logic [TOT_W-1:0]       cum_ff, cum_in;
   logic [COUNT_BITS-1:0]  peak_cnt_ff, peak_cnt_in;
   logic [LEN_W-1:0]       peak_ff, peak_in;
   logic [LEN_W-1:0]       lo_ff, lo_in;
   logic [LEN_W-1:0]       hi_ff, hi_in;
   logic                   lo_found_ff, lo_found_in;
   logic                   hi_found_ff, hi_found_in;
   logic [TOTAL_OUT_W-1:0] runs_ff, runs_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   rls_rsp_type            rsp_data_ff, rsp_data_in;

   logic                   scan_last;
   logic                   out_free;
   logic                   scanning;
   logic                   stats_init;
   logic                   report_load;
   logic [LEN_W-1:0]       rd_len;
   logic [TOT_W-1:0]       cum_new;
   logic [TOT_W:0]         cum_dbl;
   logic [LEN_W:0]         mid_sum;

   assign scan_last = (scan_ff == IDX_W'(MAX_LINE_LEN - 1));
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR:  if (scan_last) state_in = ST_RUN;
         ST_RUN:    if (img_done) state_in = ST_DRAIN;
         ST_DRAIN:  state_in = ST_SUM;
         ST_SUM:    if (scan_last) state_in = ST_RANK;
         ST_RANK:   if (scan_last) state_in = ST_FINISH;
         ST_FINISH: state_in = ST_REPORT;
         ST_REPORT: if (out_free) state_in = ST_RUN;
         default:   state_in = ST_CLEAR;
      endcase
   end

   // state outputs
   always_comb begin
      req_stall   = 1'b1;
      scanning    = 1'b0;
      stats_init  = 1'b0;
      report_load = 1'b0;
      clr_valid   = rd_valid_ff && rd_rank_ff;
      clr_addr    = rd_idx_ff;
      case (state_ff)
         ST_CLEAR: begin
            clr_valid = 1'b1;
            clr_addr  = scan_ff;
         end
         ST_RUN:    req_stall = 1'b0;
         ST_DRAIN:  stats_init = 1'b1;
         ST_SUM:    scanning = 1'b1;
         ST_RANK:   scanning = 1'b1;
         ST_FINISH: ;
         ST_REPORT: report_load = out_free;
         default:   ;
      endcase
   end

   // datapath over returned bins
   always_comb begin
      scan_addr   = scan_ff;
      scan_in     = (scanning || (state_ff == ST_CLEAR)) ?
                    (scan_last ? '0 : scan_ff + IDX_W'(1)) : '0;
      rd_valid_in = scanning;
      rd_rank_in  = (state_ff == ST_RANK);
      rd_idx_in   = scan_ff;

      rd_len  = LEN_W'(rd_idx_ff) + LEN_W'(1);
      cum_new = cum_ff + TOT_W'(rd_data);
      cum_dbl = {cum_new, 1'b0};

      total_in    = total_ff;
      cum_in      = cum_ff;
      peak_cnt_in = peak_cnt_ff;
      peak_in     = peak_ff;
      lo_in       = lo_ff;
      hi_in       = hi_ff;
      lo_found_in = lo_found_ff;
      hi_found_in = hi_found_ff;
      runs_in     = (img_done && (state_ff == ST_RUN)) ? run_total : runs_ff;

      if (stats_init) begin
         total_in    = '0;
         cum_in      = '0;
         peak_cnt_in = '0;
         peak_in     = '0;
         lo_in       = '0;
         hi_in       = '0;
         lo_found_in = 1'b0;
         hi_found_in = 1'b0;
      end else if (rd_valid_ff && !rd_rank_ff) begin
         total_in = total_ff + TOT_W'(rd_data);
         // ascending lengths, so ">=" hands a tie to the longer length
         if ((rd_data != '0) && (rd_data >= peak_cnt_ff)) begin
            peak_cnt_in = rd_data;
            peak_in     = rd_len;
         end
      end else if (rd_valid_ff) begin
         cum_in = cum_new;
         // lower middle rank: 2*cum >= total; upper middle rank: 2*cum > total
         if (!lo_found_ff && (total_ff != '0) && (cum_dbl >= {1'b0, total_ff})) begin
            lo_in       = rd_len;
            lo_found_in = 1'b1;
         end
         if (!hi_found_ff && (total_ff != '0) && (cum_dbl > {1'b0, total_ff})) begin
            hi_in       = rd_len;
            hi_found_in = 1'b1;
         end
      end

      mid_sum = {1'b0, lo_ff} + {1'b0, hi_ff};

      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (report_load) begin
         rsp_valid_in              = 1'b1;
         rsp_data_in.peak_length   = LEN_OUT_W'(peak_ff);
         rsp_data_in.median_length = LEN_OUT_W'(mid_sum[LEN_W:1]);
         rsp_data_in.run_total     = runs_ff;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      rsp_valid = rsp_valid_ff;
      rsp_data  = rsp_data_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         scan_ff      <= '0;
         rd_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         lo_found_ff  <= 1'b0;
         hi_found_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         scan_ff      <= scan_in;
         rd_valid_ff  <= rd_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         lo_found_ff  <= lo_found_in;
         hi_found_ff  <= hi_found_in;
      end
      rd_rank_ff  <= rd_rank_in;
      rd_idx_ff   <= rd_idx_in;
      total_ff    <= total_in;
      cum_ff      <= cum_in;
      peak_cnt_ff <= peak_cnt_in;
      peak_ff     <= peak_in;
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      runs_ff     <= runs_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

`default_nettype wire

// ===== tb/rls_checker.sv =====
`timescale 1ns / 1ps

module rls_checker #(
   parameter int MAX_LEN  = rls_pkg::DEF_MAX_LINE_LEN,
   parameter int CNT_BITS = rls_pkg::DEF_COUNT_BITS
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   input  wire logic                 req_stall,
   input  wire rls_pkg::rls_req_type req_data,
   input  wire logic                 rsp_valid,
   input  wire logic                 rsp_stall,
   input  wire rls_pkg::rls_rsp_type rsp_data,
   input  wire logic                 csr_write_enable,
   input  wire logic                 csr_write_data,
   output int                        fail_count,
   output int                        pending_results
);

   logic [CNT_BITS-1:0]  run_hist [0:MAX_LEN];
   logic [CNT_BITS-1:0]  image_runs;
   int                   open_len;
   logic                 count_value;
   rls_pkg::rls_rsp_type summary_q [$];
   rls_pkg::rls_rsp_type want;

   // Record the run in progress; bins and the run tally hold at full scale.
   function automatic void close_run();
      if (open_len != 0) begin
         if (run_hist[open_len] != {CNT_BITS{1'b1}})
            run_hist[open_len] = run_hist[open_len] + 1'b1;
         if (image_runs != {CNT_BITS{1'b1}})
            image_runs = image_runs + 1'b1;
         open_len = 0;
      end
   endfunction

   // Shortest length whose cumulative count passes the zero-based rank.
   function automatic int rank_length(input longint rank);
      longint cum;
      cum = 0;
      for (int len = 1; len <= MAX_LEN; len++) begin
         cum += run_hist[len];
         if (cum > rank)
            return len;
      end
      return 0;
   endfunction

   function automatic rls_pkg::rls_rsp_type summarize();
      rls_pkg::rls_rsp_type r;
      longint               total;
      longint               top_count;
      longint               runs;
      int                   top_len;
      int                   mid;
      total     = 0;
      top_count = 0;
      top_len   = 0;
      mid       = 0;
      for (int len = 1; len <= MAX_LEN; len++) begin
         total += run_hist[len];
         if (run_hist[len] != 0 && run_hist[len] >= top_count) begin
            top_count = run_hist[len];
            top_len   = len;
         end
      end
      if (total > 0)
         mid = (rank_length((total - 1) / 2) + rank_length(total / 2)) / 2;
      runs            = image_runs;
      r.peak_length   = top_len[rls_pkg::LEN_OUT_W-1:0];
      r.median_length = mid[rls_pkg::LEN_OUT_W-1:0];
      r.run_total     = (runs > 64'hFFFFFF) ? '1 : runs[rls_pkg::TOTAL_OUT_W-1:0];
      return r;
   endfunction

   function automatic void take_pixel(input rls_pkg::rls_req_type px);
      if (px.pixel == count_value) begin
         if (open_len < MAX_LEN)
            open_len++;
      end else begin
         close_run();
      end
      if (px.line_end || px.image_end)
         close_run();
      if (px.image_end) begin
         summary_q.push_back(summarize());
         for (int len = 0; len <= MAX_LEN; len++)
            run_hist[len] = '0;
         image_runs = '0;
         open_len   = 0;
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         for (int len = 0; len <= MAX_LEN; len++)
            run_hist[len] = '0;
         image_runs  = '0;
         open_len    = 0;
         count_value = 1'b1;
         summary_q.delete();
         fail_count  = 0;
      end else begin
         if (csr_write_enable)
            count_value = csr_write_data;
         if (req_valid && !req_stall)
            take_pixel(req_data);
         if (rsp_valid && !rsp_stall) begin
            if (summary_q.size() == 0) begin
               $error("unexpected result: peak %0d median %0d total %0d",
                      rsp_data.peak_length, rsp_data.median_length, rsp_data.run_total);
               fail_count++;
            end else begin
               want = summary_q.pop_front();
               if (rsp_data.peak_length !== want.peak_length) begin
                  $error("peak_length: expected %0d, actual %0d",
                         want.peak_length, rsp_data.peak_length);
                  fail_count++;
               end
               if (rsp_data.median_length !== want.median_length) begin
                  $error("median_length: expected %0d, actual %0d",
                         want.median_length, rsp_data.median_length);
                  fail_count++;
               end
               if (rsp_data.run_total !== want.run_total) begin
                  $error("run_total: expected %0d, actual %0d",
                         want.run_total, rsp_data.run_total);
                  fail_count++;
               end
            end
         end
      end
      pending_results = summary_q.size();
   end

endmodule

// ===== tb/tb_run_length_statistics_unit.sv =====
`timescale 1ns / 1ps

module tb_run_length_statistics_unit;

   localparam int MAX_LEN       = rls_pkg::DEF_MAX_LINE_LEN;
   localparam int WALK_CYCLES   = 2 * MAX_LEN + 3;
   localparam int SETTLE_CYCLES = WALK_CYCLES + 64;
   localparam int LONG_HOLD     = 3 * WALK_CYCLES + 2000;
   localparam int PHASE_ITEMS   = 110;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_stall;
   rls_pkg::rls_req_type req_data;
   logic                 rsp_valid;
   logic                 rsp_stall;
   rls_pkg::rls_rsp_type rsp_data;
   logic                 csr_write_enable;
   logic                 csr_write_data;

   int   fail_count;
   int   pending_results;
   int   send_idle_pct  = 0;
   int   recv_stall_pct = 0;
   int   hold_left      = 0;
   int   sent_items     = 0;
   int   phase_start;
   logic polarity_now   = 1'b1;

   run_length_statistics_unit u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   rls_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .fail_count       (fail_count),
      .pending_results  (pending_results)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Receiver: a long hold-off counts down here, otherwise stall at random.
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else begin
            rsp_stall <= ($urandom_range(99) < recv_stall_pct);
         end
      end
   end

   initial begin
      #100_000_000;
      $display("run_length_statistics_unit: mismatch");
      $finish;
   end

   task automatic send_req(input rls_pkg::rls_req_type item);
      bit [31:0] dice;
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         dice = $urandom;
         req_valid <= 1'b0;
         req_data  <= dice[2:0];
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      sent_items++;
   endtask

   task automatic send_pix(input bit px, input bit le, input bit ie);
      rls_pkg::rls_req_type item;
      item.pixel     = px;
      item.line_end  = le;
      item.image_end = ie;
      send_req(item);
   endtask

   // Drop valid and hold until every expected result has been taken.
   task automatic pause_sender();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_results != 0)
         @(negedge clock);
   endtask

   task automatic write_polarity(input logic value);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      polarity_now = value;
   endtask

   // One image of short lines; pixels flip level at random to form runs.
   task automatic send_image();
      rls_pkg::rls_req_type item;
      bit [31:0] dice;
      int        line_count;
      int        max_width;
      int        width;
      bit        level;
      dice       = $urandom;
      level      = dice[31];
      line_count = dice[1:0] % 3 + 1;
      max_width  = (dice[6:4] == 3'd0) ? 40 : 8;
      for (int ln = 0; ln < line_count; ln++) begin
         width = $urandom_range(max_width, 1);
         for (int col = 0; col < width; col++) begin
            dice = $urandom;
            if (dice[2:0] < 3'd3)
               level = ~level;
            item.pixel     = level;
            item.line_end  = (col == width - 1);
            item.image_end = (ln == line_count - 1) && (col == width - 1);
            // Stray line and image ends, and an image end without its line end.
            if (dice[9:4] == 6'd0)
               item.line_end = 1'b1;
            if (dice[15:10] == 6'd0)
               item.image_end = 1'b1;
            if (item.image_end && dice[18:16] == 3'd0)
               item.line_end = 1'b0;
            send_req(item);
         end
      end
   endtask

   initial begin
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_data         = '0;
      csr_write_enable = 1'b0;
      csr_write_data   = 1'b0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Lone pixel: image end closes the line.
      send_pix(1, 0, 1);
      // No runs at all.
      send_pix(0, 1, 1);
      // Runs 2, 1, 3: all tied, longest wins.
      send_pix(1, 0, 0); send_pix(1, 0, 0); send_pix(0, 0, 0); send_pix(1, 1, 0);
      send_pix(0, 0, 0); send_pix(1, 0, 0); send_pix(1, 0, 0); send_pix(1, 1, 1);
      // Same level across a line break: runs 2 and 4, even count.
      send_pix(1, 0, 0); send_pix(1, 1, 0); send_pix(1, 0, 0); send_pix(1, 0, 0);
      send_pix(1, 0, 0); send_pix(1, 0, 1);
      // Run closed by the other level at image end.
      send_pix(1, 0, 0); send_pix(0, 0, 1);
      // Runs 1, 1, 3: the shorter length is the most frequent.
      send_pix(1, 0, 0); send_pix(0, 0, 0); send_pix(1, 0, 0); send_pix(0, 0, 0);
      send_pix(1, 0, 0); send_pix(1, 0, 0); send_pix(1, 1, 1);

      for (int ph = 0; ph < 4; ph++) begin
         if (ph != 0) begin
            pause_sender();
            repeat (SETTLE_CYCLES) @(negedge clock);
            write_polarity(ph[0] == 1'b0);
         end
         case (ph)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 87; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 87; end
            default: begin send_idle_pct = 18; recv_stall_pct = 18; end
         endcase
         // Block the result side long enough for several images to back up.
         if (ph == 0) begin
            hold_left = LONG_HOLD;
            repeat (4) send_image();
         end
         phase_start = sent_items;
         while (sent_items - phase_start < PHASE_ITEMS)
            send_image();
         // Leave a run open so the next polarity meets it mid-line.
         repeat (3) send_pix(polarity_now, 0, 0);
      end

      pause_sender();
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (fail_count == 0 && pending_results == 0) begin
         $display("run_length_statistics_unit: match");
      end else begin
         $display("run_length_statistics_unit: mismatch");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
sv/rls_pkg.sv
sv/rls_ram.sv
sv/rls_run_tracker.sv
sv/rls_hist_port.sv
sv/rls_walker.sv
sv/run_length_statistics_unit.sv
tb/rls_checker.sv
tb/tb_run_length_statistics_unit.sv
